// ===== hdl/spq_pkg.sv =====
// Shared types, constants and helpers of the sorted priority queue.
package spq_pkg;

   // Number of cells in the chain (2 to 256).
   localparam int QUEUE_DEPTH = 16;
   // Width of the entry counter; it can hold QUEUE_DEPTH itself.
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Field widths fixed by the item formats.
   localparam int DATA_W   = 32;
   localparam int PRIO_W   = 8;
   localparam int COUNT5_W = 5;
   localparam int STATUS_W = 2;

   // Operation carried in tuser of the request channel.
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // One queue entry as held in a cell.
   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [PRIO_W-1:0]        prio;
   } entry_type;

   // Command broadcast to every cell; push and pop are already qualified.
   typedef struct packed {
      logic                     push;
      logic                     pop;
      logic signed [DATA_W-1:0] data;
      logic [PRIO_W-1:0]        prio;
   } cmd_type;

   // Reported entry count: the occupancy masked to five bits.
   function automatic logic [COUNT5_W-1:0] count5(input logic [CNT_W-1:0] cnt);
      logic [CNT_W+COUNT5_W-1:0] wide;
      wide = {{COUNT5_W{1'b0}}, cnt};
      return wide[COUNT5_W-1:0];
   endfunction

endpackage

// ===== hdl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and shifts it to a neighbor.
module spq_cell
   import spq_pkg::*;
(
   input  logic      clock,
   input  cmd_type   cmd,
   input  logic      occupied,
   input  entry_type left_entry,
   input  logic      left_stays,
   input  entry_type right_entry,
   output entry_type entry,
   output logic      stays
);

   entry_type entry_ff;
   entry_type entry_in;

   // The entry stays put on a push when it ranks at or above the new one.
   assign stays = occupied && (entry_ff.prio >= cmd.prio);
   assign entry = entry_ff;

   // Push inserts at the first cell that does not stay; cells behind it
   // take their left neighbor. Pop moves every entry one cell toward the head.
   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.push) begin
         if (!stays) begin
            if (left_stays) begin
               entry_in.data = cmd.data;
               entry_in.prio = cmd.prio;
            end else begin
               entry_in = left_entry;
            end
         end
      end else if (cmd.pop) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: cell chain, counter and result register.
//
// A bounded priority queue of QUEUE_DEPTH entries held in a chain of cells in
// descending priority order, the head in the first cell. A request (tuser 0
// push, 1 pop) is taken by the whole chain: every cell compares its priority with
// the pushed one in parallel and shifts toward the tail or the head at the
// same edge, so a new request can be accepted on every cycle, and its result
// appears in the output register on the next cycle. Throughput is one item
// per cycle; the only wait is back pressure on the result channel. A push to
// a full queue is dropped with status 1, a pop on an empty queue reports
// status 2; equal priorities leave in arrival order.
module sorted_priority_queue
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // [31:0] item_data, [39:32] item_priority
   input  logic        req_tuser,  // [0] mode
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata   // [31:0] popped_data, [63:32] head_data,
                                   // [64] not_empty, [69:65] entry_count,
                                   // [71:70] status
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] popped_ff, popped_in;
   logic signed [DATA_W-1:0] head_ff, head_in;
   logic [STATUS_W-1:0]      status_ff, status_in;

   logic      req_accept;
   logic      is_pop;
   logic      full;
   logic      empty;
   cmd_type   cmd;
   entry_type cell_entry [QUEUE_DEPTH];
   logic      cell_stays [QUEUE_DEPTH];

   // The request channel is ready whenever the result register is free or draining.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign is_pop = (req_tuser == MODE_POP);
   assign full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);

   // Command broadcast to the chain, qualified by the full and empty checks.
   always_comb begin
      cmd.push = req_accept && !is_pop && !full;
      cmd.pop  = req_accept && is_pop && !empty;
      cmd.data = req_tdata[31:0];
      cmd.prio = req_tdata[39:32];
   end

   // Chain of cells; the first cell sees a left neighbor that always stays.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_stays;
      logic      occupied;

      assign occupied = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_stays = 1'b1;
      end else begin : g_inner
         assign left_entry = cell_entry[i-1];
         assign left_stays = cell_stays[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_body
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (occupied),
         .left_entry  (left_entry),
         .left_stays  (left_stays),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .stays       (cell_stays[i])
      );
   end

   // Occupancy counter.
   always_comb begin
      count_in = count_ff;
      priority if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // Result fields, worked out from the chain as it stands before the edge.
   always_comb begin
      popped_in = '0;
      status_in = ST_OK;
      head_in   = '0;
      if (is_pop) begin
         if (empty) begin
            status_in = ST_EMPTY;
         end else begin
            popped_in = cell_entry[0].data;
            if (count_ff > CNT_W'(1)) begin
               head_in = cell_entry[1].data;
            end
         end
      end else begin
         if (full) begin
            status_in = ST_FULL;
            head_in   = cell_entry[0].data;
         end else if (cell_stays[0]) begin
            head_in = cell_entry[0].data;
         end else begin
            head_in = cmd.data;
         end
      end
   end

   // Output register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload; loaded with each request transfer.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         popped_ff <= popped_in;
         head_ff   <= head_in;
         status_ff <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {status_ff, count5(count_ff), (count_ff != '0), head_ff, popped_ff};

   // The counter never passes the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count above queue depth");

   // A push that fits grows the queue by exactly one.
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_pop && !full) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("push did not grow the queue");

   // A pop on a non-empty queue shrinks it by exactly one.
   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_pop && !empty) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("pop did not shrink the queue");

   // A dropped push is reported only when every cell is taken.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == ST_FULL)) |-> full)
      else $error("full status on a queue that is not full");

   // An empty-pop status always comes with an empty queue and no popped data.
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == ST_EMPTY)) |-> (empty && (popped_ff == '0)))
      else $error("empty status inconsistent with queue");

endmodule

// ===== tb/spq_checker.sv =====
`timescale 1ns / 1ps
// Checker of the sorted priority queue: watches both channels, predicts each result and compares.
module spq_checker
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   output int          mismatch_count,
   output int          pending_count
);

   // One result as the queue reports it after an operation.
   typedef struct packed {
      logic signed [DATA_W-1:0] popped;
      logic signed [DATA_W-1:0] head;
      logic                     not_empty;
      logic [COUNT5_W-1:0]      count;
      logic [STATUS_W-1:0]      status;
   } queue_view_type;

   // Predicted queue contents, head first.
   logic signed [DATA_W-1:0] held_data [QUEUE_DEPTH];
   logic [PRIO_W-1:0]        held_prio [QUEUE_DEPTH];
   int                       held_count;

   // Results predicted but not yet seen on the result channel.
   queue_view_type expected_views[$];

   initial begin
      held_count     = 0;
      mismatch_count = 0;
      pending_count  = 0;
   end

   // Applies one accepted operation to the predicted queue and records its result.
   task automatic apply_operation(input logic op, input logic signed [DATA_W-1:0] word,
                                  input logic [PRIO_W-1:0] rank);
      queue_view_type view;
      int             slot;
      view        = '0;
      view.status = ST_OK;
      if (op == MODE_PUSH) begin
         if (held_count >= QUEUE_DEPTH) begin
            view.status = ST_FULL;
         end else begin
            // The new entry goes behind every entry of greater or equal priority.
            slot = 0;
            while (slot < held_count && held_prio[slot] >= rank) slot++;
            for (int i = held_count; i > slot; i--) begin
               held_data[i] = held_data[i-1];
               held_prio[i] = held_prio[i-1];
            end
            held_data[slot] = word;
            held_prio[slot] = rank;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            view.status = ST_EMPTY;
         end else begin
            view.popped = held_data[0];
            for (int i = 1; i < held_count; i++) begin
               held_data[i-1] = held_data[i];
               held_prio[i-1] = held_prio[i];
            end
            held_count--;
         end
      end
      view.head      = (held_count > 0) ? held_data[0] : '0;
      view.not_empty = (held_count > 0);
      view.count     = COUNT5_W'(held_count);
      expected_views.push_back(view);
   endtask

   // Reports one wrong field with the time, the expected and the actual value.
   task automatic report_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endtask

   // Operations are predicted before results are checked, so a result always meets
   // the oldest expectation.
   always @(posedge clock) begin
      queue_view_type want;
      queue_view_type got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            apply_operation(req_tuser, req_tdata[31:0], req_tdata[39:32]);
         if (rsp_tvalid && rsp_tready) begin
            got.popped    = rsp_tdata[31:0];
            got.head      = rsp_tdata[63:32];
            got.not_empty = rsp_tdata[64];
            got.count     = rsp_tdata[69:65];
            got.status    = rsp_tdata[71:70];
            if (expected_views.size() == 0) begin
               mismatch_count++;
               $display("%0t: result transfer with none expected, expected none, actual %0h",
                        $time, rsp_tdata);
            end else begin
               want = expected_views.pop_front();
               if (got.popped !== want.popped)
                  report_field("popped_data", want.popped, got.popped);
               if (got.head !== want.head)
                  report_field("head_data", want.head, got.head);
               if (got.not_empty !== want.not_empty)
                  report_field("not_empty", DATA_W'(want.not_empty),
                               DATA_W'(got.not_empty));
               if (got.count !== want.count)
                  report_field("entry_count", DATA_W'(want.count), DATA_W'(got.count));
               if (got.status !== want.status)
                  report_field("status", DATA_W'(want.status), DATA_W'(got.status));
            end
         end
         pending_count = expected_views.size();
      end
   end

endmodule

// ===== tb/tb_sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// Testbench top of the sorted priority queue: clock, reset, stimulus and verdict.
module tb_sorted_priority_queue;
   import spq_pkg::*;

   localparam int RANDOM_OPS  = 1300;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // [31:0] item_data, [39:32] item_priority
   logic        req_tuser;   // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;   // [31:0] popped_data, [63:32] head_data, [64] not_empty,
                             // [69:65] entry_count, [71:70] status
   int          mismatch_count;
   int          pending_count;
   int          cycle_count;
   logic        hold_request;
   logic        sender_busy;

   sorted_priority_queue u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   spq_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit well above the slowest correct run.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Offers one operation from the next falling edge until it is taken.
   task automatic send_operation(input logic op, input logic [DATA_W-1:0] word,
                                 input logic [PRIO_W-1:0] rank);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {rank, word};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drops valid at random, never in a busy phase; mostly short, sometimes long.
   task automatic sender_pause();
      int gap;
      int pick;
      pick = $urandom_range(0, 99);
      if (sender_busy || pick < 55) gap = 0;
      else if (pick < 95) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Priorities cluster on a few values so that ties are frequent.
   function automatic logic [PRIO_W-1:0] pick_priority();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return PRIO_W'($urandom_range(0, 3));
      else if (pick < 8) return PRIO_W'($urandom);
      else return (pick == 8) ? '0 : '1;
   endfunction

   // Receiver: random back pressure, one long hold-off on request.
   initial begin
      int run;
      int pick;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            rsp_tready = (pick >= 30);
            if (pick < 3) run = $urandom_range(10, 30);
            else if (pick > 90) run = $urandom_range(50, 200);
            else run = $urandom_range(1, 4);
            repeat (run) @(negedge clock);
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      logic [PRIO_W-1:0] fill_prio [16];
      logic [DATA_W-1:0] fill_data [16];
      int                push_weight;
      int                phase_left;
      int                sent;
      fill_prio = '{8'd255, 8'd0, 8'd128, 8'd128, 8'd7, 8'd255, 8'd0, 8'd64,
                    8'd128, 8'd1, 8'd254, 8'd64, 8'd0, 8'd200, 8'd128, 8'd3};
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = MODE_PUSH;
      hold_request = 1'b0;
      sender_busy  = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: pop on an empty queue, push to an empty queue, fill with
      // extreme and tied priorities, push to a full queue, then drain a few.
      for (int i = 0; i < 16; i++) fill_data[i] = $urandom;
      fill_data[0] = 32'h7fff_ffff;
      fill_data[1] = 32'h8000_0000;
      fill_data[2] = 32'h0000_0000;
      fill_data[3] = 32'hffff_ffff;
      send_operation(MODE_POP, 32'h0, 8'h0);
      for (int i = 0; i < 16; i++) begin
         send_operation(MODE_PUSH, fill_data[i], fill_prio[i]);
         sender_pause();
      end
      send_operation(MODE_PUSH, 32'h1234_5678, 8'hff);
      for (int i = 0; i < 4; i++) begin
         send_operation(MODE_POP, $urandom, pick_priority());
         sender_pause();
      end

      // Random phases that lean toward filling, mixing or draining the queue.
      phase_left  = 0;
      push_weight = 50;
      for (sent = 0; sent < RANDOM_OPS; sent++) begin
         if (phase_left == 0) begin
            phase_left  = $urandom_range(20, 80);
            push_weight = (sent % 3 == 0) ? 85 : (sent % 3 == 1) ? 50 : 15;
            push_weight = ($urandom_range(0, 2) == 0) ? 50 : push_weight;
            sender_busy = ($urandom_range(0, 4) == 0);
         end
         phase_left--;
         if (sent == 300) hold_request = 1'b1;
         send_operation(($urandom_range(0, 99) < push_weight) ? MODE_PUSH : MODE_POP,
                        $urandom, pick_priority());
         sender_pause();
      end
      @(negedge clock);
      req_tvalid = 1'b0;

      // Let every expected result arrive, then a short drain.
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
tb/spq_checker.sv
tb/tb_sorted_priority_queue.sv
